@@ design/vidu_pkg.sv @@
package vidu_pkg;

	localparam int REF_PORT_W = 16;
	localparam int INDEX_W = 10;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK = 2'd0;
	localparam status_t STATUS_FULL = 2'd1;
	localparam status_t STATUS_ZERO = 2'd2;

endpackage

@@ design/vidu_ram.sv @@
module vidu_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/vertex_index_deduplicator_unit.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    new_mesh, vertex_ref, uv_ref, normal_ref
// out       output     out_valid/out_stall  assigned_index, is_new, status
//
// A corner is compared with the stored entries in order; a hit ends the search at that entry,
// a miss is appended once every stored entry has been read, unless the table is full, and a
// corner seen by an empty table is appended without a table read. The key table sits behind one RAM read
// port that is scanned one entry per cycle.
// A corner with a zero reference never reads the table.
// Reset clears the entry count and the handshake state; the key table is not cleared.
// A result waits in the output register while out_stall is high, and the next
// corner is taken meanwhile; a second finished result waits until that register frees.
module vertex_index_deduplicator_unit #(
	parameter int TABLE_DEPTH = 1024,
	parameter int REF_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               new_mesh,
	input  logic [vidu_pkg::REF_PORT_W-1:0]    vertex_ref,
	input  logic [vidu_pkg::REF_PORT_W-1:0]    uv_ref,
	input  logic [vidu_pkg::REF_PORT_W-1:0]    normal_ref,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [vidu_pkg::INDEX_W-1:0]       assigned_index,
	output logic                               is_new,
	output vidu_pkg::status_t                  status
);

	import vidu_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = 3 * REF_WIDTH;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] addr_q;
	logic rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [KW-1:0] key_q;
	logic [AW-1:0] res_idx_q;
	logic res_new_q;
	status_t res_status_q;
	logic out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic out_new_q;
	status_t out_status_q;

	logic [REF_WIDTH+REF_PORT_W-1:0] v_ext, t_ext, n_ext;
	logic [REF_WIDTH-1:0] v_ref, t_ref, n_ref;
	logic ref_zero;
	logic [KW-1:0] key_in;
	logic accept;
	logic issue;
	logic hit;
	logic miss;
	logic tbl_full;
	logic ram_we;
	logic [KW-1:0] ram_rdata;
	logic out_free;
	logic [AW+INDEX_W-1:0] idx_ext;

	assign v_ext = {{REF_WIDTH{1'b0}}, vertex_ref};
	assign t_ext = {{REF_WIDTH{1'b0}}, uv_ref};
	assign n_ext = {{REF_WIDTH{1'b0}}, normal_ref};
	assign v_ref = v_ext[REF_WIDTH-1:0];
	assign t_ref = t_ext[REF_WIDTH-1:0];
	assign n_ref = n_ext[REF_WIDTH-1:0];
	assign ref_zero = (v_ref == '0) || (t_ref == '0) || (n_ref == '0);
	assign key_in = {n_ref - 1'b1, t_ref - 1'b1, v_ref - 1'b1};

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign issue = (addr_q < cnt_q);
	assign hit = rd_vld_s1 && (ram_rdata == key_q);
	assign miss = !rd_vld_s1 && !issue;
	assign tbl_full = (cnt_q == DEPTH_C);
	assign ram_we = (state_q == ST_SEARCH) && miss && !tbl_full;
	assign out_free = !out_valid_q || !out_stall;
	assign idx_ext = {{INDEX_W{1'b0}}, res_idx_q};

	vidu_ram #(
		.WIDTH(KW),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(key_q),
		.raddr(addr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			addr_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						rd_vld_s1 <= 1'b0;
						if (new_mesh) begin
							cnt_q <= '0;
						end
						state_q <= ref_zero ? ST_FIN : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					rd_vld_s1 <= issue && !hit;
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end
					if (hit) begin
						state_q <= ST_FIN;
					end else if (miss) begin
						if (!tbl_full) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[AW-1:0];
		if (accept) begin
			key_q <= key_in;
			res_idx_q <= '0;
			res_new_q <= 1'b0;
			res_status_q <= ref_zero ? STATUS_ZERO : STATUS_OK;
		end
		if (state_q == ST_SEARCH) begin
			if (hit) begin
				res_idx_q <= rd_idx_s1;
			end else if (miss) begin
				if (tbl_full) begin
					res_status_q <= STATUS_FULL;
				end else begin
					res_idx_q <= cnt_q[AW-1:0];
					res_new_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_FIN && out_free) begin
			out_idx_q <= idx_ext[INDEX_W-1:0];
			out_new_q <= res_new_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign assigned_index = out_idx_q;
	assign is_new = out_new_q;
	assign status = out_status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= DEPTH_C)
		else $error("entry count exceeds table depth");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q < DEPTH_C) && (state_q == ST_SEARCH))
		else $error("table write without room");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SEARCH) || (state_q == ST_FIN))
		else $error("accepted corner not in work");
	a_new_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_new_q) |-> (out_status_q == STATUS_OK))
		else $error("new entry with bad status");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("result left while output register busy");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

	import vidu_pkg::*;

	localparam int TABLE_ENTRIES = 1024;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic               fresh;
		status_t            code;
	} corner_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  new_mesh = 1'b0;
	logic [REF_PORT_W-1:0] vertex_ref = '0;
	logic [REF_PORT_W-1:0] uv_ref = '0;
	logic [REF_PORT_W-1:0] normal_ref = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [INDEX_W-1:0]    assigned_index;
	logic                  is_new;
	status_t               status;

	logic [3*REF_PORT_W-1:0] seen_keys [TABLE_ENTRIES];
	int unsigned             seen_count = 0;
	corner_result_t          expected_index_q [$];
	corner_result_t          oldest_expected;

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;

	vertex_index_deduplicator_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.new_mesh       (new_mesh),
		.vertex_ref     (vertex_ref),
		.uv_ref         (uv_ref),
		.normal_ref     (normal_ref),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.assigned_index (assigned_index),
		.is_new         (is_new),
		.status         (status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic corner_result_t predict_vertex_index(input logic nm,
			input logic [REF_PORT_W-1:0] v, input logic [REF_PORT_W-1:0] t,
			input logic [REF_PORT_W-1:0] n);
		corner_result_t r;
		logic [3*REF_PORT_W-1:0] key;
		r = '{idx: '0, fresh: 1'b0, code: STATUS_OK};
		if (nm) begin
			seen_count = 0;
		end
		if (v == 0 || t == 0 || n == 0) begin
			r.code = STATUS_ZERO;
			return r;
		end
		key = {n - 1'b1, t - 1'b1, v - 1'b1};
		for (int unsigned i = 0; i < seen_count; i++) begin
			if (seen_keys[i] == key) begin
				r.idx = i[INDEX_W-1:0];
				return r;
			end
		end
		if (seen_count >= TABLE_ENTRIES) begin
			r.code = STATUS_FULL;
			return r;
		end
		seen_keys[seen_count] = key;
		r.idx = seen_count[INDEX_W-1:0];
		r.fresh = 1'b1;
		seen_count++;
		return r;
	endfunction

	task automatic send_corner(input logic nm, input logic [REF_PORT_W-1:0] v,
			input logic [REF_PORT_W-1:0] t, input logic [REF_PORT_W-1:0] n);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		new_mesh <= nm;
		vertex_ref <= v;
		uv_ref <= t;
		normal_ref <= n;
		expected_index_q.insert(expected_index_q.size(), predict_vertex_index(nm, v, t, n));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_index_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [REF_PORT_W-1:0] pick_ref();
		if ($urandom_range(1) == 0) begin
			return REF_PORT_W'($urandom_range(4, 1));
		end
		return REF_PORT_W'($urandom_range(65535, 1));
	endfunction

	task automatic test_directed_corners();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_corner(1'b1, 16'd1, 16'd1, 16'd1);
		send_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_corner(1'b0, 16'd1, 16'd1, 16'd1);
		send_corner(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_corner(1'b0, 16'h5555, 16'hAAAA, 16'h5555);
		send_corner(1'b0, 16'd0, 16'd5, 16'd5);
		send_corner(1'b0, 16'd5, 16'd0, 16'd5);
		send_corner(1'b0, 16'd5, 16'd5, 16'd0);
		send_corner(1'b0, 16'd0, 16'd0, 16'd0);
		send_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_corner(1'b0, 16'd1, 16'd1, 16'd2);
		send_corner(1'b0, 16'd1, 16'd2, 16'd1);
		send_corner(1'b0, 16'd2, 16'd1, 16'd1);
		send_corner(1'b1, 16'd0, 16'd1, 16'd1);
		send_corner(1'b0, 16'd1, 16'd1, 16'd1);
		send_corner(1'b1, 16'd1, 16'd1, 16'd1);
		send_corner(1'b0, 16'h8000, 16'h8000, 16'h8000);
		send_corner(1'b1, 16'h8000, 16'h8000, 16'h8000);
		send_corner(1'b0, 16'h7FFF, 16'h8000, 16'h0001);
	endtask

	task automatic test_full_table();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			send_corner(i == 0, 16'(i + 1), 16'((i * 7) % 65535 + 1), 16'(65535 - i));
		end
		send_corner(1'b0, 16'd1, 16'd1, 16'd65535);
		send_corner(1'b0, 16'd1024, 16'(1023 * 7 + 1), 16'(65535 - 1023));
		send_corner(1'b0, 16'd2000, 16'd3, 16'd4);
		send_corner(1'b0, 16'd2000, 16'd0, 16'd4);
		send_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_corner(1'b1, 16'd2000, 16'd3, 16'd4);
	endtask

	// The receiver holds off while corners keep coming, so the block backs up.
	task automatic test_output_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_reqs <= hold_reqs + 1;
		send_corner(1'b1, 16'd9, 16'd9, 16'd9);
		for (int i = 0; i < 12; i++) begin
			send_corner(1'b0, 16'($urandom_range(6, 1)), 16'd9, 16'($urandom_range(1) * 16'hFFFF));
		end
		wait_for_results();
		send_corner(1'b0, 16'd9, 16'd9, 16'd9);
	endtask

	task automatic test_random_meshes(input int items, input int idle_pct, input int stall_pct);
		logic [REF_PORT_W-1:0] pool_v [24];
		logic [REF_PORT_W-1:0] pool_t [24];
		logic [REF_PORT_W-1:0] pool_n [24];
		logic [REF_PORT_W-1:0] v, t, n;
		logic nm;
		int sent, pool_size, mesh_len, p;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < items) begin
			pool_size = $urandom_range(24, 1);
			for (int k = 0; k < pool_size; k++) begin
				pool_v[k] = pick_ref();
				pool_t[k] = pick_ref();
				pool_n[k] = pick_ref();
			end
			mesh_len = $urandom_range(40, 1);
			for (int c = 0; c < mesh_len && sent < items; c++) begin
				nm = (c == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
				p = $urandom_range(pool_size - 1);
				v = pool_v[p];
				t = pool_t[p];
				n = pool_n[p];
				if ($urandom_range(19) == 0) begin
					case ($urandom_range(2))
						0: v = '0;
						1: t = '0;
						default: n = '0;
					endcase
				end else if ($urandom_range(19) == 0) begin
					v = REF_PORT_W'($urandom_range(65535));
					t = REF_PORT_W'($urandom_range(65535));
					n = REF_PORT_W'($urandom_range(65535));
				end
				send_corner(nm, v, t, n);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_served) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_reqs;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_index_q.size() == 0) begin
				$display("%0t: unexpected result index %0d is_new %0d status %0d",
					$time, assigned_index, is_new, status);
				errors++;
			end else begin
				oldest_expected = expected_index_q.pop_front();
				if (assigned_index !== oldest_expected.idx) begin
					$display("%0t: assigned_index expected %0d got %0d",
						$time, oldest_expected.idx, assigned_index);
					errors++;
				end
				if (is_new !== oldest_expected.fresh) begin
					$display("%0t: is_new expected %0d got %0d",
						$time, oldest_expected.fresh, is_new);
					errors++;
				end
				if (status !== oldest_expected.code) begin
					$display("%0t: status expected %0d got %0d",
						$time, oldest_expected.code, status);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_full_table();
		test_output_hold_off();
		test_random_meshes(100, 0, 0);
		test_random_meshes(100, 66, 0);
		test_random_meshes(100, 0, 66);
		test_random_meshes(100, 12, 12);
		wait_for_results();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_index_q.size() == 0) begin
			$display("tb passed");
		end else begin
			if (expected_index_q.size() != 0) begin
				$display("%0t: %0d expected results never arrived", $time,
					expected_index_q.size());
			end
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("%0t: timeout", $time);
		$display("tb failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/vidu_pkg.sv
design/vidu_ram.sv
design/vertex_index_deduplicator_unit.sv
verif/tb.sv
